// File: hdl/nrmc_pkg.sv
// Shared types, constants and decode helpers for the NMEA RMC sentence parser.
package nrmc_pkg;

  localparam int unsigned ByteW  = 8;
  localparam int unsigned TagW   = 5;
  localparam int unsigned ValW   = 20;
  localparam int unsigned LenW   = 8;
  localparam int unsigned FracW  = 3;

  localparam logic [ValW-1:0]  VALUE_MAX = 20'hFFFFF;
  localparam logic [ValW-1:0]  YEAR_BASE = 20'd2000;
  localparam logic [TagW-1:0]  TAG_END   = 5'd16;

  localparam logic [ByteW-1:0] ASC_DOLLAR = 8'h24;
  localparam logic [ByteW-1:0] ASC_STAR   = 8'h2A;
  localparam logic [ByteW-1:0] ASC_COMMA  = 8'h2C;
  localparam logic [ByteW-1:0] ASC_DOT    = 8'h2E;
  localparam logic [ByteW-1:0] ASC_0      = 8'h30;
  localparam logic [ByteW-1:0] ASC_9      = 8'h39;
  localparam logic [ByteW-1:0] ASC_UA     = 8'h41;
  localparam logic [ByteW-1:0] ASC_UF     = 8'h46;
  localparam logic [ByteW-1:0] ASC_LA     = 8'h61;
  localparam logic [ByteW-1:0] ASC_LF_HEX = 8'h66;
  localparam logic [ByteW-1:0] ASC_CR     = 8'h0D;
  localparam logic [ByteW-1:0] ASC_LF     = 8'h0A;
  localparam logic [ByteW-1:0] STATUS_OK  = 8'h41;

  typedef enum logic [4:0] {
    PH_IDLE   = 5'd0,
    PH_TYPE   = 5'd1,
    PH_UTCH   = 5'd2,
    PH_UTCM   = 5'd3,
    PH_UTCS   = 5'd4,
    PH_STAT   = 5'd5,
    PH_LATD   = 5'd6,
    PH_LATM   = 5'd7,
    PH_NS     = 5'd8,
    PH_LOND   = 5'd9,
    PH_LONM   = 5'd10,
    PH_EW     = 5'd11,
    PH_SPEED  = 5'd12,
    PH_COURSE = 5'd13,
    PH_DAY    = 5'd14,
    PH_MONTH  = 5'd15,
    PH_YEAR   = 5'd16,
    PH_MODE   = 5'd17,
    PH_HEXHI  = 5'd18,
    PH_HEXLO  = 5'd19
  } nrmc_phase_e;

  typedef struct packed {
    logic             step;
    logic             clear;
    logic [FracW-1:0] frac;
  } nrmc_acc_ctl_t;

  function automatic logic [TagW-1:0] phase_tag(input nrmc_phase_e ph);
    logic [4:0] b;
    b = ph;
    return TagW'(b - 5'(PH_UTCH));
  endfunction

  function automatic nrmc_phase_e phase_succ(input nrmc_phase_e ph);
    case (ph)
      PH_UTCH:   return PH_UTCM;
      PH_UTCM:   return PH_UTCS;
      PH_UTCS:   return PH_STAT;
      PH_STAT:   return PH_LATD;
      PH_LATD:   return PH_LATM;
      PH_LATM:   return PH_NS;
      PH_NS:     return PH_LOND;
      PH_LOND:   return PH_LONM;
      PH_LONM:   return PH_EW;
      PH_EW:     return PH_SPEED;
      PH_SPEED:  return PH_COURSE;
      PH_COURSE: return PH_DAY;
      PH_DAY:    return PH_MONTH;
      PH_MONTH:  return PH_YEAR;
      PH_YEAR:   return PH_MODE;
      default:   return PH_MODE;
    endcase
  endfunction

  // Where an early comma in a fixed-width subfield resumes.
  function automatic nrmc_phase_e skip_target(input nrmc_phase_e ph);
    case (ph)
      PH_UTCH, PH_UTCM: return PH_STAT;
      PH_LATD:          return PH_NS;
      PH_LOND:          return PH_EW;
      default:          return PH_MODE;
    endcase
  endfunction

  function automatic logic [1:0] fixed_width(input nrmc_phase_e ph);
    case (ph)
      PH_UTCH, PH_UTCM, PH_LATD, PH_DAY, PH_MONTH, PH_YEAR: return 2'd2;
      PH_LOND: return 2'd3;
      default: return 2'd0;
    endcase
  endfunction

  function automatic logic [FracW-1:0] frac_digits(input nrmc_phase_e ph);
    case (ph)
      PH_UTCS:            return 3'd3;
      PH_LATM, PH_LONM:   return 3'd4;
      PH_SPEED, PH_COURSE: return 3'd2;
      default:            return 3'd0;
    endcase
  endfunction

  function automatic logic is_char_field(input nrmc_phase_e ph);
    return (ph == PH_STAT) || (ph == PH_NS) || (ph == PH_EW) || (ph == PH_MODE);
  endfunction

  function automatic logic [13:0] pow10(input logic [FracW-1:0] k);
    case (k)
      3'd0:    return 14'd1;
      3'd1:    return 14'd10;
      3'd2:    return 14'd100;
      3'd3:    return 14'd1000;
      3'd4:    return 14'd10000;
      default: return 14'd10000;
    endcase
  endfunction

  // {valid, nibble}
  function automatic logic [4:0] hex_nibble(input logic [ByteW-1:0] c);
    if (c inside {[ASC_0:ASC_9]}) begin
      return {1'b1, c[3:0]};
    end else if (c inside {[ASC_UA:ASC_UF], [ASC_LA:ASC_LF_HEX]}) begin
      return {1'b1, 4'(c[3:0] + 4'd9)};
    end else begin
      return 5'd0;
    end
  endfunction

endpackage

// File: hdl/nrmc_if.sv
// Valid/ready channel interfaces for received bytes and decoded field records.
interface nrmc_in_if;
  import nrmc_pkg::*;
  logic             valid;
  logic             ready;
  logic [ByteW-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

interface nrmc_out_if;
  import nrmc_pkg::*;
  logic            valid;
  logic            ready;
  logic [TagW-1:0] field_tag;
  logic [ValW-1:0] field_value;
  logic            sentence_last;
  logic            checksum_match;
  logic            sentence_pass;

  modport source (output valid, output field_tag, output field_value,
                  output sentence_last, output checksum_match,
                  output sentence_pass, input ready);
  modport sink   (input valid, input field_tag, input field_value,
                  input sentence_last, input checksum_match,
                  input sentence_pass, output ready);
endinterface

// File: hdl/nrmc_field_acc.sv
// Per-field decimal accumulator: digit-by-digit saturating conversion and fraction padding.
module nrmc_field_acc #(
  parameter int FIELD_CHARS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  nrmc_pkg::nrmc_acc_ctl_t      ctl_i,
  input  logic [nrmc_pkg::ByteW-1:0]   char_i,
  output logic [$clog2(FIELD_CHARS+1)-1:0] cnt_next_o,
  output logic [nrmc_pkg::ValW-1:0]    acc_o,
  output logic [nrmc_pkg::ValW-1:0]    acc_next_o,
  output logic [nrmc_pkg::ValW-1:0]    padded_o,
  output logic [nrmc_pkg::ByteW-1:0]   first_o
);
  import nrmc_pkg::*;

  localparam int CntW = $clog2(FIELD_CHARS + 1);

  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [ValW-1:0]  acc_q;
  logic             dot_q;
  logic [FracW-1:0] fd_q;
  logic [ByteW-1:0] first_q;

  logic             stored, fresh, eff_dot, is_dig, is_dot, take;
  logic [ValW-1:0]  eff_acc, stepped, acc_new;
  logic [FracW-1:0] eff_fd, fd_new, pad_k;
  logic [23:0]      sum;
  logic [33:0]      prod;

  assign stored  = ctl_i.step && (cnt_q < CntW'(FIELD_CHARS));
  assign fresh   = (cnt_q == '0);
  assign eff_acc = fresh ? '0 : acc_q;
  assign eff_dot = fresh ? 1'b0 : dot_q;
  assign eff_fd  = fresh ? '0 : fd_q;
  assign first_o = fresh ? '0 : first_q;

  assign is_dig = (char_i inside {[ASC_0:ASC_9]});
  assign is_dot = (char_i == ASC_DOT);
  assign take   = is_dig && (!eff_dot || (eff_fd < ctl_i.frac));

  assign sum     = 24'({eff_acc, 3'b000}) + 24'({eff_acc, 1'b0}) + 24'(char_i[3:0]);
  assign stepped = (sum > 24'(VALUE_MAX)) ? VALUE_MAX : sum[ValW-1:0];
  assign acc_new = take ? stepped : eff_acc;
  assign fd_new  = eff_fd + FracW'(take && eff_dot);

  assign acc_next_o = stored ? acc_new : eff_acc;
  assign cnt_next_o = stored ? CntW'(cnt_q + 1'b1) : cnt_q;
  assign acc_o      = eff_acc;

  // missing fraction digits count as zero
  assign pad_k    = ctl_i.frac - eff_fd;
  assign prod     = 34'(eff_acc) * 34'(pow10(pad_k));
  assign padded_o = (prod > 34'(VALUE_MAX)) ? VALUE_MAX : prod[ValW-1:0];

  always_comb begin
    cnt_d = cnt_q;
    if (ctl_i.clear) begin
      cnt_d = '0;
    end else if (stored) begin
      cnt_d = CntW'(cnt_q + 1'b1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (stored && !ctl_i.clear) begin
      acc_q <= acc_new;
      dot_q <= eff_dot | is_dot;
      fd_q  <= fd_new;
      if (fresh) begin
        first_q <= char_i;
      end
    end
  end

endmodule

// File: hdl/nmea_rmc_sentence_parser.sv
// Top level: NMEA RMC sentence parser, one byte in, at most one field record out.
// Each result passes through the input register, then the result register; throughput is
// one byte per cycle while the output is not held by back-pressure, set by the state
// update of the sentence phase and field accumulator, done once per accepted byte.
// Reset: asynchronous, active low; the parser waits for '$' with counters and
// checksum cleared and no record pending.
module nmea_rmc_sentence_parser #(
  parameter int FIELD_CHARS  = 8,
  parameter int MAX_SENTENCE = 128
) (
  input  logic clk_i,
  input  logic rst_ni,
  nrmc_in_if.sink    in_i,
  nrmc_out_if.source out_o
);
  import nrmc_pkg::*;

  localparam int CntW = $clog2(FIELD_CHARS + 1);

  // input register
  logic             in_vld_q;
  logic [ByteW-1:0] byte_q;

  // sentence state
  nrmc_phase_e      phase_q, phase_d;
  logic [ByteW-1:0] xor_q, xor_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [ByteW-1:0] stat_q, stat_d;
  logic [3:0]       hexhi_q, hexhi_d;
  logic             hexok_q, hexok_d;

  // result register
  logic            out_vld_q;
  logic [TagW-1:0] tag_q, tag_d;
  logic [ValW-1:0] val_q, val_d;
  logic            last_q, last_d;
  logic            match_q, match_d;
  logic            pass_q, pass_d;
  logic            emit;

  logic            advance, go;
  logic [1:0]      fw;
  logic [4:0]      nib;
  logic            match_c;
  logic [ValW-1:0] year_add;

  nrmc_acc_ctl_t   acc_ctl;
  logic [CntW-1:0] cnt_next;
  logic [ValW-1:0] acc_cur, acc_next, padded;
  logic [ByteW-1:0] first_chr;

  assign advance    = !out_vld_q || out_o.ready;
  assign go         = in_vld_q && advance;
  assign in_i.ready = !in_vld_q || advance;

  assign fw       = fixed_width(phase_q);
  assign nib      = hex_nibble(byte_q);
  assign year_add = (phase_q == PH_YEAR) ? YEAR_BASE : '0;
  assign match_c  = hexok_q && nib[4] && ({hexhi_q, nib[3:0]} == xor_q);

  nrmc_field_acc #(
    .FIELD_CHARS(FIELD_CHARS)
  ) u_acc (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .ctl_i      (acc_ctl),
    .char_i     (byte_q),
    .cnt_next_o (cnt_next),
    .acc_o      (acc_cur),
    .acc_next_o (acc_next),
    .padded_o   (padded),
    .first_o    (first_chr)
  );

  always_comb begin
    phase_d       = phase_q;
    xor_d         = xor_q;
    len_d         = len_q;
    stat_d        = stat_q;
    hexhi_d       = hexhi_q;
    hexok_d       = hexok_q;
    emit          = 1'b0;
    tag_d         = phase_tag(phase_q);
    val_d         = '0;
    last_d        = 1'b0;
    match_d       = 1'b0;
    pass_d        = 1'b0;
    acc_ctl.step  = 1'b0;
    acc_ctl.clear = 1'b0;
    acc_ctl.frac  = frac_digits(phase_q);

    if (go) begin
      if (byte_q == ASC_DOLLAR) begin
        phase_d       = PH_TYPE;
        xor_d         = '0;
        len_d         = LenW'(1);
        stat_d        = '0;
        acc_ctl.clear = 1'b1;
      end else if (phase_q == PH_IDLE) begin
        phase_d = PH_IDLE;
      end else if (byte_q == ASC_CR || byte_q == ASC_LF || len_q >= LenW'(MAX_SENTENCE)) begin
        emit    = 1'b1;
        tag_d   = TAG_END;
        val_d   = ValW'(xor_q);
        last_d  = 1'b1;
        phase_d = PH_IDLE;
      end else begin
        len_d = LenW'(len_q + 1'b1);
        case (phase_q)
          PH_HEXHI: begin
            hexhi_d = nib[3:0];
            hexok_d = nib[4];
            phase_d = PH_HEXLO;
          end
          PH_HEXLO: begin
            emit    = 1'b1;
            tag_d   = TAG_END;
            val_d   = ValW'(xor_q);
            last_d  = 1'b1;
            match_d = match_c;
            pass_d  = match_c && (stat_q == STATUS_OK);
            phase_d = PH_IDLE;
          end
          default: begin
            if (byte_q == ASC_STAR) begin
              phase_d = PH_HEXHI;
              if (phase_q == PH_MODE) begin
                emit  = 1'b1;
                val_d = ValW'(first_chr);
              end
            end else begin
              xor_d = xor_q ^ byte_q;
              if (phase_q == PH_TYPE) begin
                if (byte_q == ASC_COMMA) begin
                  phase_d       = PH_UTCH;
                  acc_ctl.clear = 1'b1;
                end
              end else if (byte_q == ASC_COMMA) begin
                acc_ctl.clear = 1'b1;
                if (phase_q != PH_MODE) begin
                  emit = 1'b1;
                  if (fw != 2'd0) begin
                    val_d   = ValW'(acc_cur + year_add);
                    phase_d = skip_target(phase_q);
                  end else if (is_char_field(phase_q)) begin
                    val_d   = ValW'(first_chr);
                    phase_d = phase_succ(phase_q);
                    if (phase_q == PH_STAT) begin
                      stat_d = first_chr;
                    end
                  end else begin
                    val_d   = padded;
                    phase_d = phase_succ(phase_q);
                  end
                end
              end else begin
                acc_ctl.step = 1'b1;
                if (fw != 2'd0 && cnt_next == CntW'(fw)) begin
                  emit          = 1'b1;
                  val_d         = ValW'(acc_next + year_add);
                  phase_d       = phase_succ(phase_q);
                  acc_ctl.clear = 1'b1;
                end
              end
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q  <= 1'b0;
      out_vld_q <= 1'b0;
      phase_q   <= PH_IDLE;
      xor_q     <= '0;
      len_q     <= '0;
      stat_q    <= '0;
      hexhi_q   <= '0;
      hexok_q   <= 1'b0;
    end else begin
      if (in_i.ready) begin
        in_vld_q <= in_i.valid;
      end
      if (advance) begin
        out_vld_q <= go && emit;
      end
      phase_q <= phase_d;
      xor_q   <= xor_d;
      len_q   <= len_d;
      stat_q  <= stat_d;
      hexhi_q <= hexhi_d;
      hexok_q <= hexok_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_i.ready && in_i.valid) begin
      byte_q <= in_i.rx_byte;
    end
    if (go && emit) begin
      tag_q   <= tag_d;
      val_q   <= val_d;
      last_q  <= last_d;
      match_q <= match_d;
      pass_q  <= pass_d;
    end
  end

  assign out_o.valid          = out_vld_q;
  assign out_o.field_tag      = tag_q;
  assign out_o.field_value    = val_q;
  assign out_o.sentence_last  = last_q;
  assign out_o.checksum_match = match_q;
  assign out_o.sentence_pass  = pass_q;

endmodule

// File: tb/nmea_rmc_sentence_parser_test.sv
// Self-checking testbench for the NMEA RMC parser: directed and random byte streams.
module nmea_rmc_sentence_parser_test;
  timeunit 1ns;
  timeprecision 1ps;
  import nrmc_pkg::*;

  localparam int FieldChars  = 8;
  localparam int MaxSentence = 128;
  localparam int WatchLimit  = 3000;
  localparam int HoldCycles  = 400;

  typedef struct packed {
    logic [TagW-1:0] tag;
    logic [ValW-1:0] value;
    logic            last;
    logic            match;
    logic            pass;
  } field_rec_t;

  logic clk;
  logic rst_n;

  nrmc_in_if  in_bus ();
  nrmc_out_if out_bus ();

  nmea_rmc_sentence_parser #(
    .FIELD_CHARS (FieldChars),
    .MAX_SENTENCE(MaxSentence)
  ) DUT (
    .clk_i (clk),
    .rst_ni(rst_n),
    .in_i  (in_bus),
    .out_o (out_bus)
  );

  // parser state as predicted
  nrmc_phase_e ps_phase;
  logic [7:0]  ps_chars [FieldChars];
  int unsigned ps_count;
  int unsigned ps_len;
  logic [7:0]  ps_xor;
  logic [7:0]  ps_status;
  logic [3:0]  ps_hex_hi;
  logic        ps_hex_ok;

  field_rec_t  pending_records [$];
  int unsigned errors;
  int unsigned bytes_sent;
  int unsigned hold_len;
  bit          send_gaps;
  bit          recv_stalls;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Field decode helpers
  // ---------------------------------------------------------------------------
  function automatic int unsigned subfield_width(input nrmc_phase_e ph);
    case (ph)
      PH_LOND: return 3;
      PH_UTCH, PH_UTCM, PH_LATD, PH_DAY, PH_MONTH, PH_YEAR: return 2;
      default: return 0;
    endcase
  endfunction

  function automatic nrmc_phase_e comma_resume(input nrmc_phase_e ph);
    if (ph == PH_UTCH || ph == PH_UTCM) return PH_STAT;
    if (ph == PH_LATD) return PH_NS;
    if (ph == PH_LOND) return PH_EW;
    return PH_MODE;
  endfunction

  function automatic int unsigned scale_digits(input nrmc_phase_e ph);
    case (ph)
      PH_UTCS:             return 3;
      PH_LATM, PH_LONM:    return 4;
      PH_SPEED, PH_COURSE: return 2;
      default:             return 0;
    endcase
  endfunction

  function automatic bit char_field(input nrmc_phase_e ph);
    return ph inside {PH_STAT, PH_NS, PH_EW, PH_MODE};
  endfunction

  function automatic nrmc_phase_e next_phase(input nrmc_phase_e ph);
    return nrmc_phase_e'(ph + 1);
  endfunction

  function automatic logic [TagW-1:0] tag_of(input nrmc_phase_e ph);
    return TagW'(ph - PH_UTCH);
  endfunction

  function automatic int unsigned push_digit(input int unsigned acc, input int unsigned d);
    int unsigned top;
    top = VALUE_MAX;
    if (acc > (top - d) / 10) return top;
    return acc * 10 + d;
  endfunction

  function automatic int unsigned scaled_value(input int unsigned frac);
    int unsigned acc;
    int unsigned fd;
    int unsigned n;
    bit          seen_dot;
    logic [7:0]  c;
    acc = 0;
    fd = 0;
    seen_dot = 1'b0;
    n = (ps_count > FieldChars) ? FieldChars : ps_count;
    for (int i = 0; i < n; i++) begin
      c = ps_chars[i];
      if (c == ASC_DOT) begin
        seen_dot = 1'b1;
      end else if (c >= ASC_0 && c <= ASC_9) begin
        if (!seen_dot) begin
          acc = push_digit(acc, c - ASC_0);
        end else if (fd < frac) begin
          acc = push_digit(acc, c - ASC_0);
          fd++;
        end
      end
    end
    while (fd < frac) begin
      acc = push_digit(acc, 0);
      fd++;
    end
    return acc;
  endfunction

  function automatic int unsigned subfield_value(input nrmc_phase_e ph);
    int unsigned v;
    v = scaled_value(0);
    if (ph == PH_YEAR) v += YEAR_BASE;
    return v;
  endfunction

  function automatic int unsigned first_char();
    return (ps_count != 0) ? ps_chars[0] : 0;
  endfunction

  function automatic bit hex_digit(input logic [7:0] c, output logic [3:0] nib);
    nib = 4'd0;
    if (c >= ASC_0 && c <= ASC_9) nib = 4'(c - ASC_0);
    else if (c >= ASC_UA && c <= ASC_UF) nib = 4'(c - ASC_UA + 10);
    else if (c >= ASC_LA && c <= ASC_LF_HEX) nib = 4'(c - ASC_LA + 10);
    else return 1'b0;
    return 1'b1;
  endfunction

  function automatic void store_record(input logic [TagW-1:0] tag, input int unsigned value,
                                       input logic last, input logic match, input logic pass);
    field_rec_t r;
    r.tag   = tag;
    r.value = ValW'(value);
    r.last  = last;
    r.match = match;
    r.pass  = pass;
    pending_records.push_back(r);
  endfunction

  function automatic void clear_parse_state();
    ps_phase  = PH_IDLE;
    ps_count  = 0;
    ps_len    = 0;
    ps_xor    = 8'd0;
    ps_status = 8'd0;
    ps_hex_hi = 4'd0;
    ps_hex_ok = 1'b0;
  endfunction

  // One accepted byte: advance the sentence state, queue the record it yields.
  function automatic void parse_rx_byte(input logic [7:0] c);
    nrmc_phase_e ph;
    int unsigned w;
    int unsigned v;
    logic [3:0]  lo;
    logic        lo_ok;
    logic        m;
    ph = ps_phase;
    if (c == ASC_DOLLAR) begin
      ps_phase  = PH_TYPE;
      ps_xor    = 8'd0;
      ps_len    = 1;
      ps_status = 8'd0;
      ps_count  = 0;
      return;
    end
    if (ph == PH_IDLE) return;
    if (c == ASC_CR || c == ASC_LF || ps_len >= MaxSentence) begin
      store_record(TAG_END, ps_xor, 1'b1, 1'b0, 1'b0);
      ps_phase = PH_IDLE;
      return;
    end
    ps_len++;
    if (ph == PH_HEXHI) begin
      ps_hex_ok = hex_digit(c, ps_hex_hi);
      ps_phase  = PH_HEXLO;
      return;
    end
    if (ph == PH_HEXLO) begin
      lo_ok = hex_digit(c, lo);
      m = ps_hex_ok && lo_ok && ({ps_hex_hi, lo} == ps_xor);
      store_record(TAG_END, ps_xor, 1'b1, m, m && (ps_status == STATUS_OK));
      ps_phase = PH_IDLE;
      return;
    end
    if (c == ASC_STAR) begin
      ps_phase = PH_HEXHI;
      if (ph == PH_MODE) store_record(tag_of(ph), first_char(), 1'b0, 1'b0, 1'b0);
      return;
    end
    ps_xor ^= c;
    if (ph == PH_TYPE) begin
      if (c == ASC_COMMA) begin
        ps_phase = PH_UTCH;
        ps_count = 0;
      end
      return;
    end
    w = subfield_width(ph);
    if (c == ASC_COMMA) begin
      if (ph == PH_MODE) begin
        ps_count = 0;
        return;
      end
      if (w != 0) begin
        v = subfield_value(ph);
        ps_phase = comma_resume(ph);
      end else if (char_field(ph)) begin
        v = first_char();
        if (ph == PH_STAT) ps_status = 8'(v);
        ps_phase = next_phase(ph);
      end else begin
        v = scaled_value(scale_digits(ph));
        ps_phase = next_phase(ph);
      end
      ps_count = 0;
      store_record(tag_of(ph), v, 1'b0, 1'b0, 1'b0);
      return;
    end
    if (ps_count < FieldChars) begin
      ps_chars[ps_count] = c;
      ps_count++;
    end
    if (w != 0 && ps_count == w) begin
      store_record(tag_of(ph), subfield_value(ph), 1'b0, 1'b0, 1'b0);
      ps_phase = next_phase(ph);
      ps_count = 0;
    end
  endfunction

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [7:0] b);
    if (send_gaps && $urandom_range(0, 5) == 0) begin
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    in_bus.valid   <= 1'b1;
    in_bus.rx_byte <= b;
    do @(posedge clk); while (!in_bus.ready);
    parse_rx_byte(b);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  function automatic logic [7:0] xor_of(input string s);
    logic [7:0] x;
    x = 8'd0;
    for (int i = 0; i < s.len(); i++) x ^= s[i];
    return x;
  endfunction

  function automatic string framed(input string body, input bit lower);
    if (lower) return $sformatf("$%s*%02x", body, xor_of(body));
    return $sformatf("$%s*%02X", body, xor_of(body));
  endfunction

  function automatic string digit_run(input int unsigned n);
    string s;
    s = "";
    repeat (n) s = $sformatf("%s%0d", s, $urandom_range(0, 9));
    return s;
  endfunction

  function automatic string decimal_text(input int unsigned whole, input int unsigned frac);
    if (frac == 0) return digit_run(whole);
    return $sformatf("%s.%s", digit_run(whole), digit_run(frac));
  endfunction

  function automatic string either(input string a, input string b);
    return $urandom_range(0, 1) ? a : b;
  endfunction

  // Mostly the well-formed text, sometimes an empty, short or malformed field.
  function automatic string odd_or(input string normal);
    case ($urandom_range(0, 15))
      0:       return "";
      1:       return digit_run($urandom_range(1, 3));
      2:       return $sformatf("%s.%s.%0d", digit_run(1), digit_run(2), $urandom_range(0, 9));
      3:       return $sformatf("%c%s", $urandom_range(8'h47, 8'h5A), digit_run(2));
      default: return normal;
    endcase
  endfunction

  function automatic string random_rmc_body();
    string s;
    string stat;
    case ($urandom_range(0, 7))
      0:       stat = "V";
      1:       stat = "";
      2:       stat = $sformatf("%c", $urandom_range(8'h41, 8'h5A));
      default: stat = "A";
    endcase
    s = $sformatf("%s,%s,%s,%s,%s,%s,%s,%s,%s,%s,%s,%s",
                  either("GPRMC", "GNRMC"),
                  odd_or($sformatf("%s.%s", digit_run(6), digit_run($urandom_range(0, 3)))),
                  stat,
                  odd_or(decimal_text(4, $urandom_range(0, 6))),
                  either("N", "S"),
                  odd_or(decimal_text(5, $urandom_range(0, 6))),
                  either("E", "W"),
                  odd_or(decimal_text($urandom_range(1, 9), $urandom_range(0, 3))),
                  odd_or(decimal_text($urandom_range(1, 3), $urandom_range(0, 3))),
                  odd_or(digit_run(6)),
                  odd_or(decimal_text(3, 1)),
                  either("E", "W"));
    if ($urandom_range(0, 3) != 0) s = $sformatf("%s,%s", s, either(either("A", "D"), "N"));
    return s;
  endfunction

  task automatic send_random_sentence();
    string       body;
    string       text;
    logic [7:0]  sum;
    int unsigned flaw;
    int          spot;
    int          cut_at;
    bit          broken;
    flaw   = $urandom_range(0, 99);
    spot   = -1;
    cut_at = -1;
    broken = 1'b0;
    body   = random_rmc_body();
    if (flaw < 10) body = body.substr(0, $urandom_range(0, body.len() - 2));
    sum = xor_of(body);
    if (flaw >= 10 && flaw < 18) sum ^= 8'($urandom_range(1, 255));
    if ($urandom_range(0, 1)) text = $sformatf("$%s*%02x", body, sum);
    else text = $sformatf("$%s*%02X", body, sum);
    if (flaw >= 18 && flaw < 30) spot = $urandom_range(1, text.len() - 1);
    if (flaw >= 30 && flaw < 36) cut_at = $urandom_range(1, text.len() - 1);
    for (int i = 0; i < text.len(); i++) begin
      if (i == spot) send_byte(8'($urandom_range(0, 255)));
      if (i == cut_at) begin
        send_byte($urandom_range(0, 1) ? ASC_CR : ASC_LF);
        broken = 1'b1;
        break;
      end
      send_byte(text[i]);
    end
    if (!broken && $urandom_range(0, 4) < 3) begin
      send_byte(ASC_CR);
      send_byte(ASC_LF);
    end
    if ($urandom_range(0, 4) == 0) repeat ($urandom_range(1, 3)) send_byte(8'($urandom_range(0, 255)));
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  task automatic test_idle_noise();
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte(ASC_CR);
    send_byte(ASC_LF);
    send_byte(ASC_STAR);
    send_byte(ASC_COMMA);
    send_text("GPRMC,1");
  endtask

  task automatic test_good_sentences();
    send_text(framed({"GPRMC,225446.25,A,4916.4512,N,12311.1203,W,000.5,054.7,",
                      "191194,020.3,E,A"}, 1'b0));
    send_byte(ASC_CR);
    send_byte(ASC_LF);
    send_text(framed("GNRMC,081836,V,3751.65,S,14507.36,E,360.0,359.99,010100,,,N", 1'b1));
  endtask

  task automatic test_line_breaks();
    send_text("$GPRMC,1234");
    send_byte(ASC_CR);
    send_text("$GPRMC,010203.4,A,12");
    send_byte(ASC_LF);
    send_text("$GPRMC,,A,,,,,,,,,,,A*");
    send_byte(ASC_CR);
    send_text("$GPRMC*4");
    send_byte(ASC_LF);
  endtask

  task automatic test_checksum_faults();
    string b;
    b = "GPRMC,,A,,,,,,,,,,,A";
    send_text({"$", b, "*G0"});
    send_text({"$", b, "*0g"});
    send_text($sformatf("$%s*%02X", b, xor_of(b) ^ 8'h01));
    send_text($sformatf("$%s*%02X", b, xor_of(b) ^ 8'h80));
  endtask

  task automatic test_short_fields();
    send_text(framed("GPRMC,1,A,4,N,12,W,,,1,,,A", 1'b0));
    send_text(framed("GPRMC,123,V,48,N,011,E,1,2,011,1.5,W,D", 1'b0));
    send_text(framed("GPRMC,000000,A,0000,N,00000,E,0,0,01021,", 1'b0));
    send_text(framed("GPRMC,,,,,,,,,,,,", 1'b0));
    send_text(framed("GPRMC", 1'b0));
    send_text(framed("GPRMC,12", 1'b0));
    send_text(framed("GPRMC,120000,A,1,S,1,W,5.5", 1'b1));
    send_text(framed("GPRMC,120000,A,1,S,1,W,,,010100,", 1'b0));
  endtask

  task automatic test_number_edges();
    send_text(framed({"GPRMC,235959.9999,A,8959.99999999,N,17959.123456789,W,",
                      "99999999.99,1x2.3.4,311299,,,D"}, 1'b0));
    send_text(framed("GPRMC,000000.,AVVVVVVVVVVV,0000.,NSSSSSSSSSS,00000,E,.5,7.,999999", 1'b0));
  endtask

  task automatic test_restart();
    send_text("$GPRMC,123519,A,48");
    send_text("$$GPRMC,123519,A,48");
    send_text(framed("GPRMC,123519,A,4807.038,N,01131.000,E,022.4,084.4,230394,003.1,W",
                     1'b0));
  endtask

  task automatic test_overlong();
    logic [7:0] b;
    send_text("$GPRMC,");
    repeat (140) begin
      do b = 8'($urandom_range(0, 255));
      while (b == ASC_DOLLAR || b == ASC_STAR || b == ASC_CR || b == ASC_LF);
      send_byte(b);
    end
    send_byte(ASC_LF);
  endtask

  task automatic test_backpressure();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    hold_len    = HoldCycles;
    send_text(framed({"GPRMC,225446.25,A,4916.4512,N,12311.1203,W,000.5,",
                      "054.7,191194,020.3,E,A"}, 1'b0));
  endtask

  task automatic test_random_sentences(input int unsigned budget);
    int unsigned start;
    start = bytes_sent;
    while (bytes_sent - start < budget) begin
      send_gaps   = $urandom_range(0, 3) != 0;
      recv_stalls = $urandom_range(0, 3) != 0;
      send_random_sentence();
    end
  endtask

  task automatic test_drain();
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    send_random_sentence();
  endtask

  // ---------------------------------------------------------------------------
  // Receiver, checker, watchdog
  // ---------------------------------------------------------------------------
  initial begin
    out_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_len != 0) begin
        out_bus.ready <= 1'b0;
        repeat (hold_len) @(posedge clk);
        hold_len = 0;
        out_bus.ready <= 1'b1;
      end else if (recv_stalls && $urandom_range(0, 6) == 0) begin
        out_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 9)) @(posedge clk);
        out_bus.ready <= 1'b1;
      end else begin
        out_bus.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    field_rec_t got;
    field_rec_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      got.tag   = out_bus.field_tag;
      got.value = out_bus.field_value;
      got.last  = out_bus.sentence_last;
      got.match = out_bus.checksum_match;
      got.pass  = out_bus.sentence_pass;
      if (pending_records.size() == 0) begin
        errors++;
        $display("%0t: unexpected beat tag %0d value %0d last %0b match %0b pass %0b",
                 $time, got.tag, got.value, got.last, got.match, got.pass);
      end else begin
        want = pending_records.pop_front();
        if (got !== want) begin
          errors++;
          $display("%0t: expected tag %0d value %0d last %0b match %0b pass %0b", $time,
                   want.tag, want.value, want.last, want.match, want.pass);
          $display("%0t:   actual tag %0d value %0d last %0b match %0b pass %0b", $time,
                   got.tag, got.value, got.last, got.match, got.pass);
        end
      end
    end
  end

  initial begin
    int unsigned quiet;
    quiet = 0;
    while (quiet < WatchLimit) begin
      @(posedge clk);
      if (!rst_n || (in_bus.valid && in_bus.ready) || (out_bus.valid && out_bus.ready))
        quiet = 0;
      else
        quiet++;
    end
    $display("[nmea_rmc_sentence_parser] ERROR");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n = 1'b0;
    in_bus.valid   <= 1'b0;
    in_bus.rx_byte <= 8'd0;
    errors      = 0;
    bytes_sent  = 0;
    hold_len    = 0;
    send_gaps   = 1'b0;
    recv_stalls = 1'b0;
    clear_parse_state();
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    send_gaps   = 1'b1;
    recv_stalls = 1'b1;
    test_idle_noise();
    test_good_sentences();
    test_line_breaks();
    test_checksum_faults();
    test_short_fields();
    test_number_edges();
    test_restart();
    test_overlong();
    test_backpressure();
    test_random_sentences(60);
    test_drain();
    in_bus.valid <= 1'b0;
    while (pending_records.size() != 0) @(posedge clk);
    repeat (16) @(posedge clk);
    if (errors == 0)
      $display("[nmea_rmc_sentence_parser] OK");
    else
      $display("[nmea_rmc_sentence_parser] ERROR");
    $finish;
  end

endmodule
